@@ src/multibit_trie_route_lookup_core_defines.svh @@
// Assertion macros for the route lookup core checker.
`ifndef MULTIBIT_TRIE_ROUTE_LOOKUP_CORE_DEFINES_SVH
`define MULTIBIT_TRIE_ROUTE_LOOKUP_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MTRIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check under another name; the message is passed through unchanged.
`define MTRIE_ASSERT_PORT(lbl, prop, msg) \
    `MTRIE_ASSERT(lbl, prop, msg)

`endif

@@ src/mtrie_pkg.sv @@
// Types and constants shared by the route lookup core.
`default_nettype none

package mtrie_pkg;

    localparam int STRIDE_BITS    = 8;
    localparam int STRIDE_ENTRIES = 256;
    localparam int LEVELS         = 4;
    localparam int RANK_W         = 6;
    localparam int ADDR_BITS      = 32;
    localparam int LEN_W          = 6;
    localparam int MAX_LEN        = 32;
    localparam int SPAN_W         = 9;
    localparam int STATUS_W       = 2;

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_LOOKUP = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_WALK,
        S_EXP
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    function automatic logic [STRIDE_BITS-1:0] addr_byte(
        input logic [ADDR_BITS-1:0] a,
        input logic [1:0]           lvl
    );
        logic [STRIDE_BITS-1:0] b;
        unique case (lvl)
            2'd0:    b = a[31:24];
            2'd1:    b = a[23:16];
            2'd2:    b = a[15:8];
            default: b = a[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ src/mtrie_mem.sv @@
// Simple dual-port entry store with registered read data.
`default_nettype none

module mtrie_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 30
) (
    input  wire                     clk,
    input  mtrie_pkg::mem_ctl_t     ctl,
    input  wire [ADDR_W-1:0]        wr_addr,
    input  wire [DATA_W-1:0]        wr_data,
    input  wire [ADDR_W-1:0]        rd_addr,
    output logic [DATA_W-1:0]       rd_data
);
    import mtrie_pkg::*;

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/mtrie_ctrl.sv @@
// Sequencer for clear, lookup walk, insert walk and prefix expansion.
`default_nettype none

module mtrie_ctrl #(
    parameter int TABLE_COUNT = 256,
    parameter int PORT_BITS   = 16,
    parameter int TBL_W       = 8,
    parameter int ADDR_W      = 16,
    parameter int DATA_W      = 30
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  mtrie_pkg::func_t             in_func,
    input  wire [31:0]                   in_addr,
    input  wire [5:0]                    in_len,
    input  wire [PORT_BITS-1:0]          in_port,
    output logic                         res_valid,
    input  wire                          res_ready,
    output logic [PORT_BITS-1:0]         res_port,
    output mtrie_pkg::status_t           res_status,
    output mtrie_pkg::mem_ctl_t          mem_ctl,
    output logic [ADDR_W-1:0]            wr_addr,
    output logic [DATA_W-1:0]            wr_data,
    output logic [ADDR_W-1:0]            rd_addr,
    input  wire [DATA_W-1:0]             rd_data
);
    import mtrie_pkg::*;

    localparam int CNT_W = $clog2(TABLE_COUNT + 1);
    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(TABLE_COUNT * STRIDE_ENTRIES - 1);

    state_t                 state_reg, state_next;
    logic [1:0]             lvl_reg, lvl_next;
    logic [TBL_W-1:0]       table_reg, table_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic [RANK_W-1:0]      rank_reg, rank_next;
    logic [PORT_BITS-1:0]   port_reg, port_next;
    logic [1:0]             exp_lvl_reg, exp_lvl_next;
    logic [SPAN_W-1:0]      span_reg, span_next;
    logic [SPAN_W-1:0]      rd_i_reg, rd_i_next;
    logic                   pend_reg, pend_next;
    logic [ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]       free_reg, free_next;
    logic                   found_reg, found_next;
    logic [PORT_BITS-1:0]   hit_port_reg, hit_port_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;

    logic [RANK_W-1:0]      e_rank;
    logic [PORT_BITS-1:0]   e_port;
    logic [TBL_W-1:0]       e_child;
    logic [LEN_W-1:0]       sat_len;
    logic [ADDR_BITS-1:0]   masked_addr;
    logic [1:0]             in_exp_lvl;
    logic [LEN_W-1:0]       in_end;
    logic [3:0]             in_shift;
    logic [STRIDE_BITS-1:0] exp_idx;

    assign e_rank  = rd_data[DATA_W-1 -: RANK_W];
    assign e_port  = rd_data[TBL_W +: PORT_BITS];
    assign e_child = rd_data[TBL_W-1:0];

    assign sat_len     = (in_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_len;
    assign masked_addr = in_addr & (32'hFFFF_FFFF << (LEN_W'(MAX_LEN) - sat_len));
    assign in_exp_lvl  = (sat_len == '0) ? 2'd0 : 2'((sat_len - 6'd1) >> 3);
    assign in_end      = LEN_W'({in_exp_lvl, 3'b000}) + LEN_W'(STRIDE_BITS);
    assign in_shift    = 4'(in_end - sat_len);
    assign exp_idx     = addr_byte(addr_reg, lvl_reg) + rd_i_reg[STRIDE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            free_reg  <= CNT_W'(1);
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg       <= lvl_next;
        table_reg     <= table_next;
        addr_reg      <= addr_next;
        rank_reg      <= rank_next;
        port_reg      <= port_next;
        exp_lvl_reg   <= exp_lvl_next;
        span_reg      <= span_next;
        rd_i_reg      <= rd_i_next;
        pend_addr_reg <= pend_addr_next;
        found_reg     <= found_next;
        hit_port_reg  <= hit_port_next;
    end

    always_comb
    begin
        logic [TBL_W-1:0] next_tbl;
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        table_next     = table_reg;
        addr_next      = addr_reg;
        rank_next      = rank_reg;
        port_next      = port_reg;
        exp_lvl_next   = exp_lvl_reg;
        span_next      = span_reg;
        rd_i_next      = rd_i_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        free_next      = free_reg;
        found_next     = found_reg;
        hit_port_next  = hit_port_reg;
        clr_next       = clr_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        res_port       = '0;
        res_status     = STATUS_OK;
        mem_ctl        = '0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_addr        = '0;
        next_tbl       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = clr_reg;
                clr_next      = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ENTRY)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mem_ctl.rd_en = 1'b1;
                    lvl_next      = 2'd0;
                    table_next    = '0;
                    found_next    = 1'b0;
                    hit_port_next = '0;
                    rank_next     = sat_len + 6'd1;
                    port_next     = in_port;
                    exp_lvl_next  = in_exp_lvl;
                    span_next     = SPAN_W'(1) << in_shift;
                    if (in_func == FUNC_LOOKUP)
                    begin
                        addr_next  = in_addr;
                        rd_addr    = {TBL_W'(0), addr_byte(in_addr, 2'd0)};
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        addr_next  = masked_addr;
                        rd_addr    = {TBL_W'(0), addr_byte(masked_addr, 2'd0)};
                        state_next = S_WALK;
                    end
                end
            end

            S_LOOK:
            begin
                if ((e_child == '0) || (lvl_reg == 2'(LEVELS - 1)))
                begin
                    res_valid  = 1'b1;
                    res_port   = (e_rank != '0) ? e_port : hit_port_reg;
                    res_status = ((e_rank != '0) || found_reg) ? STATUS_OK : STATUS_MISS;
                    if (res_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    if (e_rank != '0)
                    begin
                        found_next    = 1'b1;
                        hit_port_next = e_port;
                    end
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = {e_child, addr_byte(addr_reg, lvl_reg + 2'd1)};
                    table_next    = e_child;
                    lvl_next      = lvl_reg + 2'd1;
                end
            end

            S_WALK:
            begin
                if (lvl_reg == exp_lvl_reg)
                begin
                    rd_i_next  = '0;
                    state_next = S_EXP;
                end
                else if (e_child != '0)
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = {e_child, addr_byte(addr_reg, lvl_reg + 2'd1)};
                    table_next    = e_child;
                    lvl_next      = lvl_reg + 2'd1;
                end
                else if (free_reg >= CNT_W'(TABLE_COUNT))
                begin
                    res_valid  = 1'b1;
                    res_status = STATUS_FULL;
                    if (res_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    next_tbl      = free_reg[TBL_W-1:0];
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = {table_reg, addr_byte(addr_reg, lvl_reg)};
                    wr_data       = {e_rank, e_port, next_tbl};
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = {next_tbl, addr_byte(addr_reg, lvl_reg + 2'd1)};
                    table_next    = next_tbl;
                    free_next     = free_reg + CNT_W'(1);
                    lvl_next      = lvl_reg + 2'd1;
                end
            end

            S_EXP:
            begin
                if (pend_reg && (e_rank < rank_reg))
                begin
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = pend_addr_reg;
                    wr_data       = {rank_reg, port_reg, e_child};
                end
                if (rd_i_reg != span_reg)
                begin
                    mem_ctl.rd_en  = 1'b1;
                    rd_addr        = {table_reg, exp_idx};
                    rd_i_next      = rd_i_reg + SPAN_W'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = {table_reg, exp_idx};
                end
                else if (!pend_reg)
                begin
                    res_valid = 1'b1;
                    if (res_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/multibit_trie_route_lookup_core.sv @@
// Top level of the IPv4 longest-prefix-match route lookup core.
`default_nettype none

// IPv4 longest-prefix-match engine over a four-level trie with 8-bit strides,
// held in one synchronous entry memory of TABLE_COUNT x 256 entries. After
// reset the core sweeps the memory clear, one entry per cycle, and accepts no
// word meanwhile. One item is in work at a time. A lookup visits one to four
// levels, each a dependent read of the entry memory, and its result is then
// registered in the output register. An insert walks the levels down to the
// level of the prefix, then reads and writes back each expanded entry through
// the single write port of the memory; the span of expanded entries is
// 2^(level end - prefix length), at most 256. A result waits in the output
// register while the next item is accepted.
module multibit_trie_route_lookup_core #(
    parameter int TABLE_COUNT = 256,
    parameter int PORT_BITS   = 16
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    // address [31:0], prefix_len [37:32], route_port [37+PORT_BITS:38], zero pad
    input  wire [((38 + PORT_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // func [0]
    input  wire                                    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    // out_port [PORT_BITS-1:0], zero pad
    output logic [((PORT_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status [1:0]
    output logic [1:0]                             m_axis_tuser
);
    import mtrie_pkg::*;

    localparam int TBL_W  = $clog2(TABLE_COUNT);
    localparam int ADDR_W = TBL_W + STRIDE_BITS;
    localparam int DATA_W = RANK_W + PORT_BITS + TBL_W;
    localparam int DEPTH  = TABLE_COUNT * STRIDE_ENTRIES;
    localparam int OUT_W  = ((PORT_BITS + 7) / 8) * 8;

    logic                  res_valid;
    logic                  res_ready;
    logic [PORT_BITS-1:0]  res_port;
    status_t               res_status;
    mem_ctl_t              mem_ctl;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_W-1:0]     wr_data;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_W-1:0]     rd_data;
    logic                  out_valid_reg;
    logic [PORT_BITS-1:0]  out_port_reg;
    status_t               out_status_reg;

    assign res_ready = !out_valid_reg || m_axis_tready;

    mtrie_ctrl #(
        .TABLE_COUNT (TABLE_COUNT),
        .PORT_BITS   (PORT_BITS),
        .TBL_W       (TBL_W),
        .ADDR_W      (ADDR_W),
        .DATA_W      (DATA_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_func    (func_t'(s_axis_tuser)),
        .in_addr    (s_axis_tdata[31:0]),
        .in_len     (s_axis_tdata[37:32]),
        .in_port    (s_axis_tdata[38 +: PORT_BITS]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_port   (res_port),
        .res_status (res_status),
        .mem_ctl    (mem_ctl),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    mtrie_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_port_reg   <= res_port;
            out_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_port_reg);
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire

@@ src/mtrie_checker.sv @@
// Port-level checker for the route lookup core, bound to the top level.
`default_nettype none
`include "multibit_trie_route_lookup_core_defines.svh"

module mtrie_checker #(
    parameter int PORT_BITS = 16
) (
    input wire                                    clk,
    input wire                                    rst_n,
    input wire                                    s_axis_tvalid,
    input wire                                    s_axis_tready,
    input wire                                    m_axis_tvalid,
    input wire                                    m_axis_tready,
    input wire [((PORT_BITS + 7) / 8) * 8 - 1:0]  m_axis_tdata,
    input wire [1:0]                              m_axis_tuser
);
    import mtrie_pkg::*;

    `MTRIE_ASSERT_PORT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped while stalled")
    `MTRIE_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second word accepted during work")
    `MTRIE_ASSERT(a_result_from_work, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result appeared without work")
    `MTRIE_ASSERT(a_miss_port_zero, m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0), "nonzero port on miss or full")

endmodule

bind multibit_trie_route_lookup_core mtrie_checker #(
    .PORT_BITS (PORT_BITS)
) u_mtrie_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/sv/tb_multibit_trie_route_lookup_core.sv @@
// Testbench for the route lookup core: directed table, three random flow-control phases.
`timescale 1ns / 1ps

module tb_multibit_trie_route_lookup_core;
    import mtrie_pkg::*;

    localparam int TABLE_COUNT = 256;
    localparam int PORT_BITS   = 16;
    localparam int TDATA_W     = ((38 + PORT_BITS + 7) / 8) * 8;
    localparam int MDATA_W     = ((PORT_BITS + 7) / 8) * 8;
    localparam int ENTRY_TOTAL = TABLE_COUNT * STRIDE_ENTRIES;
    localparam int PHASE_WORDS = 540;

    typedef struct {
        logic [PORT_BITS-1:0] port;
        status_t              status;
    } answer_t;

    typedef struct {
        func_t                func;
        logic [31:0]          addr;
        logic [LEN_W-1:0]     len;
        logic [PORT_BITS-1:0] port;
        bit                   typed;
        logic [PORT_BITS-1:0] exp_port;
        status_t              exp_status;
    } route_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [MDATA_W-1:0]   m_axis_tdata;
    logic [1:0]           m_axis_tuser;

    logic                 word_typed = 1'b0;
    logic [PORT_BITS-1:0] word_exp_port = '0;
    status_t              word_exp_status = STATUS_OK;

    bit [RANK_W-1:0]      entry_rank  [ENTRY_TOTAL];
    bit [PORT_BITS-1:0]   entry_port  [ENTRY_TOTAL];
    bit [SPAN_W-1:0]      entry_child [ENTRY_TOTAL];
    int                   pool_next;

    answer_t              answer_q [$];
    route_row_t           dir_rows [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int n_insert = 0;
    int n_lookup = 0;
    int n_full = 0;
    int n_hit = 0;
    int n_miss = 0;

    logic [7:0] top_bytes [8] = '{8'd10, 8'd172, 8'd192, 8'd1, 8'd0, 8'd255, 8'd64, 8'd128};

    multibit_trie_route_lookup_core #(
        .TABLE_COUNT(TABLE_COUNT),
        .PORT_BITS  (PORT_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic status_t route_insert(
        input logic [31:0]          a,
        input logic [LEN_W-1:0]     len_in,
        input logic [PORT_BITS-1:0] p
    );
        int          len;
        int          tbl;
        int          lvl_end;
        int          idx;
        int          e;
        logic [31:0] m;
        len = (len_in > MAX_LEN) ? MAX_LEN : int'(len_in);
        m = (len == 0) ? 32'd0 : (a & (32'hFFFF_FFFF << (32 - len)));
        tbl = 0;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            lvl_end = STRIDE_BITS * (lvl + 1);
            idx = (m >> (24 - STRIDE_BITS * lvl)) & 8'hFF;
            if (len <= lvl_end)
            begin
                for (int i = 0; i < (1 << (lvl_end - len)); i++)
                begin
                    e = tbl * STRIDE_ENTRIES + ((idx + i) & 8'hFF);
                    if (entry_rank[e] < len + 1)
                    begin
                        entry_rank[e] = RANK_W'(len + 1);
                        entry_port[e] = p;
                    end
                end
                return STATUS_OK;
            end
            e = tbl * STRIDE_ENTRIES + idx;
            if (entry_child[e] == 0)
            begin
                if (pool_next >= TABLE_COUNT)
                    return STATUS_FULL;
                entry_child[e] = SPAN_W'(pool_next);
                pool_next++;
            end
            tbl = int'(entry_child[e]);
        end
        return STATUS_OK;
    endfunction

    function automatic status_t route_lookup(
        input  logic [31:0]          a,
        output logic [PORT_BITS-1:0] p
    );
        int tbl;
        int e;
        bit hit;
        tbl = 0;
        hit = 1'b0;
        p = '0;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            e = tbl * STRIDE_ENTRIES + ((a >> (24 - STRIDE_BITS * lvl)) & 8'hFF);
            if (entry_rank[e] != 0)
            begin
                p = entry_port[e];
                hit = 1'b1;
            end
            if (entry_child[e] == 0)
                break;
            tbl = int'(entry_child[e]);
        end
        return hit ? STATUS_OK : STATUS_MISS;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic add_row(input func_t f, input logic [31:0] a, input logic [LEN_W-1:0] l,
                           input logic [PORT_BITS-1:0] p, input bit typed,
                           input logic [PORT_BITS-1:0] ep, input status_t es);
        route_row_t r;
        r.func = f;
        r.addr = a;
        r.len = l;
        r.port = p;
        r.typed = typed;
        r.exp_port = ep;
        r.exp_status = es;
        dir_rows.push_back(r);
    endtask

    task automatic drive_word(input route_row_t r);
        logic [TDATA_W-1:0] w;
        w = '0;
        w[31:0] = r.addr;
        w[37:32] = r.len;
        w[37+PORT_BITS:38] = r.port;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        s_axis_tuser <= r.func;
        word_typed <= r.typed;
        word_exp_port <= r.exp_port;
        word_exp_status <= r.exp_status;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : scoreboard
        answer_t              want;
        answer_t              got;
        logic [31:0]          in_addr;
        logic [LEN_W-1:0]     in_len;
        logic [PORT_BITS-1:0] in_port;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_addr = s_axis_tdata[31:0];
                in_len = s_axis_tdata[37:32];
                in_port = s_axis_tdata[37+PORT_BITS:38];
                if (func_t'(s_axis_tuser) == FUNC_INSERT)
                begin
                    want.port = '0;
                    want.status = route_insert(in_addr, in_len, in_port);
                    n_insert++;
                    if (want.status == STATUS_FULL)
                        n_full++;
                end
                else
                begin
                    want.status = route_lookup(in_addr, want.port);
                    n_lookup++;
                    if (want.status == STATUS_OK)
                        n_hit++;
                    else
                        n_miss++;
                end
                if (word_typed)
                begin
                    want.port = word_exp_port;
                    want.status = word_exp_status;
                end
                answer_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.port = m_axis_tdata[PORT_BITS-1:0];
                got.status = status_t'(m_axis_tuser);
                if (answer_q.size() == 0)
                    report_mismatch("result with nothing outstanding", 32'(m_axis_tuser), 32'd0);
                else
                begin
                    want = answer_q.pop_front();
                    if (got.port !== want.port)
                        report_mismatch("out_port", 32'(got.port), 32'(want.port));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("timeout with %0d results outstanding", answer_q.size());
        $display("tb_multibit_trie_route_lookup_core: FAIL");
        $finish;
    end

    initial
    begin
        route_row_t r;
        logic [7:0] b1;
        logic [7:0] b2;
        int         pick;

        for (int i = 0; i < ENTRY_TOTAL; i++)
        begin
            entry_rank[i] = '0;
            entry_port[i] = '0;
            entry_child[i] = '0;
        end
        pool_next = 1;

        add_row(FUNC_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1, 16'h0000, STATUS_MISS);
        add_row(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1, 16'h0000, STATUS_MISS);
        add_row(FUNC_INSERT, 32'h0A00_0000, 6'd8,  16'h0001, 1, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0A01_0203, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_INSERT, 32'h0A01_0000, 6'd16, 16'hFFFF, 1, 16'h0000, STATUS_OK);
        add_row(FUNC_INSERT, 32'h0A01_0200, 6'd24, 16'h1234, 1, 16'h0000, STATUS_OK);
        add_row(FUNC_INSERT, 32'h0A01_0203, 6'd32, 16'h8000, 1, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0A01_0203, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0A01_0204, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0A01_0309, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0B00_0000, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_INSERT, 32'hC0A8_FFFF, 6'd20, 16'h0042, 1, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'hC0A8_FF01, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'hC0A8_EF01, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_INSERT, 32'h0102_0304, 6'd63, 16'h0777, 1, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0102_0304, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0102_0305, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_INSERT, 32'h0A00_0000, 6'd8,  16'h0002, 1, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0A09_0909, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_INSERT, 32'hDEAD_BEEF, 6'd0,  16'h0BAD, 1, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0C00_0001, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_INSERT, 32'h0A00_0000, 6'd7,  16'h00AA, 1, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0B02_0304, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'h0AC8_0000, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);
        add_row(FUNC_INSERT, 32'hAC10_0000, 6'd9,  16'h5555, 1, 16'h0000, STATUS_OK);
        add_row(FUNC_LOOKUP, 32'hAC7F_FFFF, 6'd0,  16'h0000, 0, 16'h0000, STATUS_OK);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 46;
        foreach (dir_rows[i])
            drive_word(dir_rows[i]);
        hold_until_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 29 : 0;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(99);
                b1 = 8'($urandom_range(3) * 85);
                b2 = 8'($urandom_range(3) * 85);
                r.typed = 1'b0;
                r.exp_port = '0;
                r.exp_status = STATUS_OK;
                r.addr = {top_bytes[$urandom_range(7)], b1, b2, 8'($urandom_range(255))};
                r.port = PORT_BITS'($urandom);
                r.len = LEN_W'($urandom_range(63));
                if (pick < 32)
                begin
                    r.func = FUNC_INSERT;
                    r.len = LEN_W'($urandom_range(32));
                end
                else if (pick < 37)
                begin
                    r.func = FUNC_INSERT;
                    r.addr = $urandom;
                end
                else
                begin
                    r.func = FUNC_LOOKUP;
                    if (pick >= 85)
                        r.addr = $urandom;
                end
                drive_word(r);
            end
            hold_until_drained();
        end

        repeat (300) @(posedge clk);
        if (answer_q.size() != 0)
            report_mismatch("results never delivered", 32'(answer_q.size()), 32'd0);
        $display("covered %0d inserts (%0d refused for want of a free table), %0d lookups",
                 n_insert, n_full, n_lookup);
        $display("lookups hit %0d and missed %0d; %0d tables taken from the pool",
                 n_hit, n_miss, pool_next - 1);
        if (mismatches == 0)
            $display("tb_multibit_trie_route_lookup_core: PASS");
        else
            $display("tb_multibit_trie_route_lookup_core: FAIL");
        $finish;
    end

endmodule
